// File: hdl/lcnc_pkg.sv
`default_nettype none

package lcnc_pkg;

   // Input word and decimal working widths
   localparam int unsigned NumBits   = 63;
   localparam int unsigned BcdDigits = 19;
   localparam int unsigned BcdBits   = 4 * BcdDigits;
   localparam int unsigned BitCntW   = $clog2(NumBits);
   localparam int unsigned CountW    = 5;
   localparam int unsigned PcBits    = 3;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_INVALID = 2'd0;
   localparam kind_type KIND_AMEX    = 2'd1;
   localparam kind_type KIND_MASTER  = 2'd2;
   localparam kind_type KIND_VISA    = 2'd3;

   // Datapath operation selected by the control word
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DABBLE,
      OP_COPY,
      OP_SCAN,
      OP_EMIT
   } op_type;

   // Jump condition; the jump goes to target when true, else to the next step
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_BITS_LEFT,
      COND_SCAN_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [PcBits-1:0] pc_type;

   typedef struct packed {
      logic     take;
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // Program step addresses
   localparam pc_type STEP_WAIT   = 3'd0;
   localparam pc_type STEP_DABBLE = 3'd1;
   localparam pc_type STEP_COPY   = 3'd2;
   localparam pc_type STEP_SCAN   = 3'd3;
   localparam pc_type STEP_EMIT   = 3'd4;
   localparam pc_type STEP_RETURN = 3'd5;

   // Microprogram ROM
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         STEP_WAIT: begin
            w = '{take: 1'b1, op: OP_LOAD, cond: COND_NO_INPUT, target: STEP_WAIT};
         end
         STEP_DABBLE: begin
            w = '{take: 1'b0, op: OP_DABBLE, cond: COND_BITS_LEFT, target: STEP_DABBLE};
         end
         STEP_COPY: begin
            w = '{take: 1'b0, op: OP_COPY, cond: COND_NEVER, target: STEP_WAIT};
         end
         STEP_SCAN: begin
            w = '{take: 1'b0, op: OP_SCAN, cond: COND_SCAN_MORE, target: STEP_SCAN};
         end
         STEP_EMIT: begin
            w = '{take: 1'b0, op: OP_EMIT, cond: COND_OUT_BUSY, target: STEP_EMIT};
         end
         STEP_RETURN: begin
            w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
         end
         default: begin
            w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hdl/luhn_card_number_classifier.sv
`default_nettype none

// Luhn card-number check and issuer classification. One card number enters
// per transaction on req_, one result leaves per transaction on rsp_. A small
// microprogram steps a plain datapath: 63 double-dabble steps turn the binary
// number into 19 BCD digits, then one digit per cycle is folded into the Luhn
// sum (mod 10) and counted, at most MAX_DIGITS of them. The next number is
// taken only after the last result has been written to the output register;
// the double-dabble loop is the longest part of the work. A finished result
// sits in the output register, and the next number is taken while it waits
// there.
module luhn_card_number_classifier
   import lcnc_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 19
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [NumBits-1:0] req_card_number,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_card_kind,
   output      logic               rsp_luhn_ok,
   output      logic [CountW-1:0]  rsp_digit_count
);

   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DIGITS);

   // Sequencer and datapath registers
   pc_type              pc_ff, pc_in;
   logic [NumBits-1:0]  bin_ff, bin_in;
   logic [BcdBits-1:0]  bcd_ff, bcd_in;
   logic [BcdBits-1:0]  rest_ff, rest_in;
   logic [BitCntW-1:0]  bits_ff, bits_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [3:0]          sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [CountW-1:0]   rsp_count_ff, rsp_count_in;

   ctrl_word_type       cw;
   logic                req_take;
   logic                out_free;
   logic                scan_more;
   logic                bits_left;
   logic                jump;
   logic [BcdBits-1:0]  adj;
   logic [3:0]          digit;
   logic [4:0]          dbl;
   logic [4:0]          luhn_add;
   logic [4:0]          total;
   kind_type            kind;

   // Control word fetch and status
   assign cw        = ucode_rom(pc_ff);
   assign req_stall = !cw.take;
   assign req_take  = req_valid && cw.take;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_more = (rest_ff != '0) && (count_ff < MaxCount);
   assign bits_left = (bits_ff != '0);

   // Jump decision and next step
   always_comb begin
      case (cw.cond)
         COND_NEVER:     jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NO_INPUT:  jump = !req_take;
         COND_BITS_LEFT: jump = bits_left;
         COND_SCAN_MORE: jump = scan_more;
         COND_OUT_BUSY:  jump = !out_free;
         default:        jump = 1'b1;
      endcase
      pc_in = jump ? cw.target : pc_ff + pc_type'(1);
   end

   // Double-dabble add-3 correction, one per BCD digit
   always_comb begin
      for (int i = 0; i < BcdDigits; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   // Luhn contribution of the current digit, sum kept mod 10
   always_comb begin
      digit    = rest_ff[3:0];
      dbl      = {digit, 1'b0};
      if (count_ff[0]) begin
         luhn_add = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
      end else begin
         luhn_add = {1'b0, digit};
      end
      total    = {1'b0, sum_ff} + luhn_add;
   end

   // Issuer by length and leading digits
   always_comb begin
      kind = KIND_INVALID;
      if (count_ff == 5'd15 && bcd_ff[59:56] == 4'd3
          && (bcd_ff[55:52] == 4'd4 || bcd_ff[55:52] == 4'd7)) begin
         kind = KIND_AMEX;
      end else if (count_ff == 5'd16 && bcd_ff[75:64] == '0) begin
         if (bcd_ff[63:60] == 4'd5 && bcd_ff[59:56] inside {[4'd1:4'd5]}) begin
            kind = KIND_MASTER;
         end else if (bcd_ff[63:60] == 4'd4) begin
            kind = KIND_VISA;
         end
      end else if (count_ff == 5'd13 && bcd_ff[51:48] == 4'd4) begin
         kind = KIND_VISA;
      end
   end

   // Datapath next values per operation
   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      rest_in      = rest_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      case (cw.op)
         OP_LOAD: begin
            if (req_take) begin
               bin_in  = req_card_number;
               bcd_in  = '0;
               bits_in = BitCntW'(NumBits - 1);
            end
         end
         OP_DABBLE: begin
            bcd_in = {adj[BcdBits-2:0], bin_ff[NumBits-1]};
            bin_in = {bin_ff[NumBits-2:0], 1'b0};
            if (bits_left) begin
               bits_in = bits_ff - BitCntW'(1);
            end
         end
         OP_COPY: begin
            rest_in  = bcd_ff;
            count_in = '0;
            sum_in   = '0;
         end
         OP_SCAN: begin
            if (scan_more) begin
               rest_in  = rest_ff >> 4;
               count_in = count_ff + CountW'(1);
               sum_in   = (total >= 5'd10) ? 4'(total - 5'd10) : total[3:0];
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = (sum_ff == 4'd0);
               rsp_kind_in  = (sum_ff == 4'd0) ? kind : KIND_INVALID;
               rsp_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      rest_ff      <= rest_in;
      bits_ff      <= bits_in;
      count_ff     <= count_in;
      sum_ff       <= sum_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_kind   = rsp_kind_ff;
   assign rsp_luhn_ok     = rsp_ok_ff;
   assign rsp_digit_count = rsp_count_ff;

endmodule

`default_nettype wire

// File: hdl/lcnc_checker.sv
`default_nettype none

module lcnc_checker
   import lcnc_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 19
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [1:0]        rsp_card_kind,
   input wire logic              rsp_luhn_ok,
   input wire logic [CountW-1:0] rsp_digit_count
);

   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DIGITS);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_card_kind)
         && $stable(rsp_luhn_ok) && $stable(rsp_digit_count))
      else $error("stalled result changed");

   // A classified card must have passed the check
   a_kind_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_card_kind != KIND_INVALID |-> rsp_luhn_ok)
      else $error("card classified without Luhn pass");

   // Issuer agrees with length
   a_kind_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_card_kind != KIND_AMEX || rsp_digit_count == 5'd15)
         && (rsp_card_kind != KIND_MASTER || rsp_digit_count == 5'd16)
         && (rsp_card_kind != KIND_VISA
             || rsp_digit_count == 5'd13 || rsp_digit_count == 5'd16))
      else $error("issuer does not match digit count");

   // Digit count stays within the scan limit
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= MaxCount)
      else $error("digit count beyond limit");

endmodule

bind luhn_card_number_classifier lcnc_checker #(.MAX_DIGITS(MAX_DIGITS)) u_lcnc_checker (.*);

`default_nettype wire
